FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a property on the same edge.
`define CHK_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Check that a condition implies a property on the next edge.
`define CHK_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/kmpt_pkg.sv
// Shared types, codes and ordering function for the keyed min-priority table.
// No dependencies.
`timescale 1ns / 1ps
package kmpt_pkg;

  localparam int unsigned ENTRIES = 64;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_ERASE  = 2'd1,
    OP_GET    = 2'd2,
    OP_GETMIN = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_REMOVE,
    ST_INSERT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic        [31:0] edge_id;
    logic signed [31:0] shade_value;
    logic        [31:0] priority_req;
    logic        [31:0] node_key;
  } entry_t;

  typedef struct packed {
    logic   remove;
    logic   insert;
    entry_t ref_ent;
    entry_t new_ent;
  } cell_ctrl_t;

  // Order by priority, then by key.
  function automatic logic entry_less(entry_t a, entry_t b);
    entry_less = (a.priority_req < b.priority_req) ||
                 ((a.priority_req == b.priority_req) && (a.node_key < b.node_key));
  endfunction

endpackage

FILE: rtl/kmpt_cell.sv
// One cell of the sorted entry chain: holds an entry and shifts with its neighbors.
// Depends on kmpt_pkg.
`timescale 1ns / 1ps
module kmpt_cell (
  input  logic                clk,
  input  logic                rst,
  input  kmpt_pkg::cell_ctrl_t ctrl,
  input  logic                left_valid,
  input  kmpt_pkg::entry_t    left_ent,
  input  logic                right_valid,
  input  kmpt_pkg::entry_t    right_ent,
  output logic                valid,
  output kmpt_pkg::entry_t    ent,
  output logic                hit
);

  logic             valid_next;
  kmpt_pkg::entry_t ent_next;
  logic             new_before_own;
  logic             new_before_left;

  assign hit = valid && (ent.node_key == ctrl.new_ent.node_key);
  assign new_before_own  = !valid || kmpt_pkg::entry_less(ctrl.new_ent, ent);
  assign new_before_left = left_valid && kmpt_pkg::entry_less(ctrl.new_ent, left_ent);

  always_comb begin
    valid_next = valid;
    ent_next   = ent;
    if (ctrl.remove) begin
      // close the gap: every cell at or past the removed entry pulls from the right
      if (valid && !kmpt_pkg::entry_less(ent, ctrl.ref_ent)) begin
        valid_next = right_valid;
        ent_next   = right_ent;
      end
    end else if (ctrl.insert) begin
      if (new_before_own) begin
        if (new_before_left) begin
          valid_next = 1'b1;
          ent_next   = left_ent;
        end else if (left_valid) begin
          valid_next = 1'b1;
          ent_next   = ctrl.new_ent;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    ent <= ent_next;
  end

endmodule

FILE: rtl/keyed_min_priority_table_core.sv
// Top level of the keyed min-priority table: control sequencer and cell chain.
// Depends on kmpt_pkg and kmpt_cell.
`timescale 1ns / 1ps
// Entries sit in a chain of cells kept sorted by priority, then key, so the
// minimum is always in the first cell. A transfer runs the lookup step, then
// the shift steps it needs (remove: erase of a present key; insert: new key;
// remove then re-insert: update of a present key; none: get, get minimum,
// dropped update), then the result step. The result register lets the next
// input transfer be accepted while a result waits on the output side.
module keyed_min_priority_table_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode[1:0], node_key[33:2], priority_req[65:34], shade_value[97:66],
  // edge_id[129:98], zero fill
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // missing[0], out_key[32:1], out_priority[64:33], out_value[96:65],
  // out_edge[128:97], table_empty[129], status[130], zero fill
  output logic [135:0] m_tdata
);

  localparam int unsigned N = kmpt_pkg::ENTRIES;

  kmpt_pkg::state_t     state, state_next;
  kmpt_pkg::op_t        op;
  kmpt_pkg::entry_t     req;
  kmpt_pkg::entry_t     hit_ent;
  logic                 found;
  kmpt_pkg::cell_ctrl_t ctrl;

  logic             cell_valid [N];
  kmpt_pkg::entry_t cell_ent   [N];
  logic [N-1:0]     cell_hit;
  kmpt_pkg::entry_t hit_or;

  logic             res_missing;
  kmpt_pkg::entry_t res_ent;
  logic             res_status;

  // marks that the insert step ran, so a now-full table is not taken as a drop
  logic ins_done;

  assign s_tready = (state == kmpt_pkg::ST_IDLE);

  assign ctrl.remove  = (state == kmpt_pkg::ST_REMOVE);
  assign ctrl.insert  = (state == kmpt_pkg::ST_INSERT);
  assign ctrl.ref_ent = hit_ent;
  assign ctrl.new_ent = req;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic             lv;
      kmpt_pkg::entry_t le;
      logic             rv;
      kmpt_pkg::entry_t re;
      if (g == 0) begin : g_first
        assign lv = 1'b1;
        assign le = '0;
      end else begin : g_mid
        assign lv = cell_valid[g-1];
        assign le = cell_ent[g-1];
      end
      if (g == N - 1) begin : g_last
        assign rv = 1'b0;
        assign re = '0;
      end else begin : g_inner
        assign rv = cell_valid[g+1];
        assign re = cell_ent[g+1];
      end
      kmpt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .left_valid (lv),
        .left_ent   (le),
        .right_valid(rv),
        .right_ent  (re),
        .valid      (cell_valid[g]),
        .ent        (cell_ent[g]),
        .hit        (cell_hit[g])
      );
    end
  endgenerate

  always_comb begin
    hit_or = '0;
    for (int i = 0; i < N; i++) begin
      hit_or = hit_or | (cell_hit[i] ? cell_ent[i] : '0);
    end
  end

  always_comb begin
    state_next  = state;
    res_missing = 1'b0;
    res_ent     = '0;
    res_status  = 1'b0;
    unique case (state)
      kmpt_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = kmpt_pkg::ST_LOOKUP;
        end
      end
      kmpt_pkg::ST_LOOKUP: begin
        state_next = kmpt_pkg::ST_FINISH;
        case (op)
          kmpt_pkg::OP_UPDATE: begin
            if (|cell_hit) begin
              state_next = kmpt_pkg::ST_REMOVE;
            end else if (!cell_valid[N-1]) begin
              state_next = kmpt_pkg::ST_INSERT;
            end
          end
          kmpt_pkg::OP_ERASE: begin
            if (|cell_hit) begin
              state_next = kmpt_pkg::ST_REMOVE;
            end
          end
          default: ;
        endcase
      end
      kmpt_pkg::ST_REMOVE: begin
        state_next = (op == kmpt_pkg::OP_UPDATE) ? kmpt_pkg::ST_INSERT
                                                 : kmpt_pkg::ST_FINISH;
      end
      kmpt_pkg::ST_INSERT: begin
        state_next = kmpt_pkg::ST_FINISH;
      end
      kmpt_pkg::ST_FINISH: begin
        unique case (op)
          kmpt_pkg::OP_UPDATE: begin
            res_missing = !found && cell_valid[N-1] && !ins_done;
            res_status  = res_missing;
            res_ent     = res_missing ? '0 : req;
          end
          kmpt_pkg::OP_ERASE, kmpt_pkg::OP_GET: begin
            res_missing = !found;
            res_ent     = found ? hit_ent : '0;
          end
          kmpt_pkg::OP_GETMIN: begin
            res_missing = !cell_valid[0];
            res_ent     = cell_valid[0] ? cell_ent[0] : '0;
          end
          default: ;
        endcase
        if (!m_tvalid || m_tready) begin
          state_next = kmpt_pkg::ST_IDLE;
        end
      end
      default: state_next = kmpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kmpt_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      ins_done <= 1'b0;
    end else begin
      state <= state_next;
      if (state == kmpt_pkg::ST_IDLE) begin
        ins_done <= 1'b0;
      end else if (state == kmpt_pkg::ST_INSERT) begin
        ins_done <= 1'b1;
      end
      if (state == kmpt_pkg::ST_FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == kmpt_pkg::ST_IDLE && s_tvalid) begin
      op                  <= kmpt_pkg::op_t'(s_tdata[1:0]);
      req.node_key        <= s_tdata[33:2];
      req.priority_req    <= s_tdata[65:34];
      req.shade_value     <= s_tdata[97:66];
      req.edge_id         <= s_tdata[129:98];
    end
    if (state == kmpt_pkg::ST_LOOKUP) begin
      found   <= |cell_hit;
      hit_ent <= hit_or;
    end
    if (state == kmpt_pkg::ST_FINISH && (!m_tvalid || m_tready)) begin
      m_tdata <= {5'd0, res_status, !cell_valid[0], res_ent.edge_id,
                  res_ent.shade_value, res_ent.priority_req, res_ent.node_key,
                  res_missing};
    end
  end

endmodule

FILE: rtl/kmpt_checker.sv
// Port-level checks on the keyed min-priority table, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kmpt_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata
);

  `CHK_IMPL(a_status_missing, clk, rst, m_tvalid && m_tdata[130], m_tdata[0],
    "dropped update not flagged missing")
  `CHK_IMPL(a_missing_zero, clk, rst, m_tvalid && m_tdata[0], m_tdata[128:1] == 128'd0,
    "missing result carries nonzero entry fields")
  `CHK_NEXT(a_no_back_to_back_accept, clk, rst, s_tvalid && s_tready, !s_tready,
    "input accepted while previous transfer in progress")
  `CHK_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
    "stalled result changed")

endmodule

bind keyed_min_priority_table_core kmpt_checker u_kmpt_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
